// ----- rtl/gcbm_pkg.sv -----
// Shared types, codes and constants of the lexer input buffer.
`default_nettype none
package gcbm_pkg;

   localparam int unsigned OFS_W       = 16;
   localparam int unsigned STORE_AW    = 15;
   localparam int unsigned STORE_DEPTH = 1 << STORE_AW;
   localparam int unsigned REQ_W       = 32;
   localparam int unsigned RSP_W       = 80;
   localparam int unsigned CSR_AW      = 2;
   localparam int unsigned CSR_DW      = 15;

   localparam logic [7:0]       HUNDRED   = 8'd100;
   localparam logic [OFS_W-1:0] LEN_LIMIT = 16'd32767;

   // x / 100 == (x * RECIP_100) >> RECIP_SHIFT, exact for any x below 2^24
   localparam logic [25:0] RECIP_100   = 26'd42949673;
   localparam int unsigned RECIP_SHIFT = 32;

   localparam logic [1:0]        MODE_RESET  = 2'd1;
   localparam logic [7:0]        STEP_RESET  = 8'd15;
   localparam logic [CSR_DW-1:0] START_RESET = 15'd200;

   typedef enum logic [3:0] {
      ACT_APPEND    = 4'd0,
      ACT_COMPACT   = 4'd1,
      ACT_READ_NEXT = 4'd2,
      ACT_MARK      = 4'd3,
      ACT_RETRACT   = 4'd4,
      ACT_RESET     = 4'd5,
      ACT_REWIND    = 4'd6,
      ACT_CLEAR     = 4'd7,
      ACT_READ_AT   = 4'd8
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_REFUSED = 2'd1,
      STATUS_BAD_CFG = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      GROW_FIXED = 2'd0,
      GROW_ADD   = 2'd1,
      GROW_MUL   = 2'd2
   } grow_mode_type;

   typedef enum logic [1:0] {
      CSR_MODE  = 2'd0,
      CSR_STEP  = 2'd1,
      CSR_START = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_GROW,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                wr_en;
      logic                rd_en;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          wdata;
   } mem_req_type;

endpackage : gcbm_pkg
`default_nettype wire

// ----- rtl/gcbm_store.sv -----
// Byte store: single-port synchronous RAM with registered read data.
`default_nettype none
module gcbm_store (
   input  logic                 clock,
   input  gcbm_pkg::mem_req_type mem_req,
   output logic [7:0]           rdata
);
   import gcbm_pkg::*;

   logic [7:0] mem [0:STORE_DEPTH-1];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rdata_ff <= mem[mem_req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule : gcbm_store
`default_nettype wire

// ----- rtl/gcbm_grow.sv -----
// Multiplicative growth: cap + (max - cap) * step / 100, or max when that adds nothing; three pipeline stages.
`default_nettype none
module gcbm_grow #(
   parameter int unsigned MAX_CAPACITY = 32766
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [gcbm_pkg::OFS_W-1:0] cap,
   input  logic [7:0]                 step,
   output logic                       done,
   output logic [gcbm_pkg::OFS_W-1:0] grown
);
   import gcbm_pkg::*;

   localparam logic [OFS_W-1:0] MaxCap   = OFS_W'(MAX_CAPACITY);
   localparam logic [OFS_W:0]   MaxCapX  = (OFS_W + 1)'(MAX_CAPACITY);
   localparam int unsigned      PROD_W   = OFS_W + 8;
   localparam int unsigned      RPROD_W  = PROD_W + 26;

   logic [PROD_W-1:0]  prod_ff;
   logic [OFS_W-1:0]   quot_ff;
   logic [OFS_W-1:0]   grown_ff;
   logic               v1_ff, v2_ff, v3_ff;
   logic [OFS_W-1:0]   diff;
   logic [RPROD_W-1:0] rprod;
   logic [OFS_W:0]     sum;

   assign diff  = MaxCap - cap;
   assign rprod = RPROD_W'(prod_ff) * RPROD_W'(RECIP_100);
   assign sum   = {1'b0, cap} + {1'b0, quot_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(diff) * PROD_W'(step);
      quot_ff <= rprod[RECIP_SHIFT +: OFS_W];
      // zero increment or reaching the ceiling both land on the ceiling
      grown_ff <= (quot_ff != '0 && sum < MaxCapX) ? sum[OFS_W-1:0] : MaxCap;
   end

   assign done  = v3_ff;
   assign grown = grown_ff;

endmodule : gcbm_grow
`default_nettype wire

// ----- rtl/growable_char_buffer_with_mark_top.sv -----
// Lexer input buffer with mark and retract: control, offsets, config and result register.
// An accepted word goes through the execute and done states; read next / read at add
// a RAM read state, and an append that grows capacity multiplicatively waits on the growth pipe.
// One word in flight; a new word is taken only once the sequencer is back in idle.
// A finished result waits in the output register while the next word is accepted.
// Synchronous reset: offsets and eob zero, config to defaults, capacity 200; RAM not cleared.
`default_nettype none
module growable_char_buffer_with_mark_top #(
   parameter int unsigned MAX_CAPACITY = 32766
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // action[3:0], symbol[11:4], position[26:12]
   input  logic [gcbm_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // status[1:0], data[9:2], end_of_buffer[10], fill_level[25:11], read_position[40:26],
   // mark_position[55:41], current_capacity[70:56], is_full[71], is_empty[72]
   output logic [gcbm_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                        csr_wen,
   input  logic [gcbm_pkg::CSR_AW-1:0] csr_addr,
   input  logic [gcbm_pkg::CSR_DW-1:0] csr_wdata
);
   import gcbm_pkg::*;

   localparam logic [OFS_W-1:0] MaxCap   = OFS_W'(MAX_CAPACITY);
   localparam logic [OFS_W:0]   MaxCapX  = (OFS_W + 1)'(MAX_CAPACITY);
   localparam logic [OFS_W:0]   MaxCapP1 = (OFS_W + 1)'(MAX_CAPACITY) + 1'b1;

   state_type        state_ff, state_in;
   logic [1:0]       mode_ff, mode_in;
   logic [7:0]       step_ff, step_in;
   logic [CSR_DW-1:0] start_ff, start_in;
   logic [OFS_W-1:0] add_ff, add_in;
   logic [OFS_W-1:0] rd_ff, rd_in;
   logic [OFS_W-1:0] mark_ff, mark_in;
   logic [OFS_W-1:0] cap_ff, cap_in;
   logic             eob_ff, eob_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [3:0]       act_ff, act_in;
   logic [7:0]       sym_ff, sym_in;
   logic [14:0]      pos_ff, pos_in;
   status_type       status_ff, status_in;
   logic [7:0]       data_ff, data_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic             eff_fixed;
   logic             cfg_ok;
   logic [OFS_W:0]   add_sum;
   mem_req_type      mem_req;
   logic [7:0]       mem_rdata;
   logic             grow_start;
   logic             grow_done;
   logic [OFS_W-1:0] grow_cap;

   gcbm_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   gcbm_grow #(
      .MAX_CAPACITY (MAX_CAPACITY)
   ) u_grow (
      .clock (clock),
      .reset (reset),
      .start (grow_start),
      .cap   (cap_ff),
      .step  (step_ff),
      .done  (grow_done),
      .grown (grow_cap)
   );

   assign eff_fixed = (mode_ff == GROW_FIXED) || (step_ff == '0);
   assign add_sum   = {1'b0, cap_ff} + (OFS_W + 1)'(step_ff);

   always_comb begin
      if ({1'b0, start_ff} > MaxCap) begin
         cfg_ok = 1'b0;
      end else if (eff_fixed) begin
         cfg_ok = (start_ff != '0);
      end else if (mode_ff == GROW_ADD) begin
         cfg_ok = 1'b1;
      end else if (mode_ff == GROW_MUL) begin
         cfg_ok = (step_ff <= HUNDRED);
      end else begin
         cfg_ok = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      step_in      = step_ff;
      start_in     = start_ff;
      add_in       = add_ff;
      rd_in        = rd_ff;
      mark_in      = mark_ff;
      cap_in       = cap_ff;
      eob_in       = eob_ff;
      act_in       = act_ff;
      sym_in       = sym_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_req      = '0;
      grow_start   = 1'b0;
      req_tready   = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               act_in   = req_tdata[3:0];
               sym_in   = req_tdata[11:4];
               pos_in   = req_tdata[26:12];
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            status_in = STATUS_OK;
            data_in   = '0;
            state_in  = ST_DONE;
            if (!cfg_ok) begin
               status_in = STATUS_BAD_CFG;
            end else begin
               unique case (act_ff)
                  ACT_APPEND: begin
                     if (add_ff < cap_ff) begin
                        mem_req.wr_en = 1'b1;
                        mem_req.addr  = add_ff[STORE_AW-1:0];
                        mem_req.wdata = sym_ff;
                        add_in        = add_ff + 1'b1;
                     end else if (eff_fixed || cap_ff >= MaxCap) begin
                        status_in = STATUS_REFUSED;
                     end else if (mode_ff == GROW_ADD) begin
                        if (add_sum > MaxCapP1) begin
                           status_in = STATUS_REFUSED;
                        end else begin
                           cap_in = (add_sum > MaxCapX) ? MaxCap : add_sum[OFS_W-1:0];
                           mem_req.wr_en = 1'b1;
                           mem_req.addr  = add_ff[STORE_AW-1:0];
                           mem_req.wdata = sym_ff;
                           add_in        = add_ff + 1'b1;
                        end
                     end else begin
                        grow_start = 1'b1;
                        state_in   = ST_GROW;
                     end
                  end
                  ACT_COMPACT: begin
                     if (add_ff >= LEN_LIMIT) begin
                        status_in = STATUS_REFUSED;
                     end else begin
                        mem_req.wr_en = 1'b1;
                        mem_req.addr  = add_ff[STORE_AW-1:0];
                        mem_req.wdata = sym_ff;
                        add_in        = add_ff + 1'b1;
                        cap_in        = add_ff + 1'b1;
                     end
                  end
                  ACT_READ_NEXT: begin
                     if (rd_ff == add_ff) begin
                        eob_in = 1'b1;
                     end else begin
                        eob_in        = 1'b0;
                        mem_req.rd_en = 1'b1;
                        mem_req.addr  = rd_ff[STORE_AW-1:0];
                        rd_in         = rd_ff + 1'b1;
                        state_in      = ST_READ;
                     end
                  end
                  ACT_MARK: begin
                     if ({1'b0, pos_ff} <= add_ff) begin
                        mark_in = {1'b0, pos_ff};
                     end else begin
                        status_in = STATUS_REFUSED;
                     end
                  end
                  ACT_RETRACT: begin
                     if (rd_ff != '0) begin
                        rd_in = rd_ff - 1'b1;
                     end else begin
                        status_in = STATUS_REFUSED;
                     end
                  end
                  ACT_RESET: begin
                     rd_in = mark_ff;
                  end
                  ACT_REWIND: begin
                     rd_in   = '0;
                     mark_in = '0;
                  end
                  ACT_CLEAR: begin
                     add_in  = '0;
                     rd_in   = '0;
                     mark_in = '0;
                     eob_in  = 1'b0;
                  end
                  ACT_READ_AT: begin
                     if ({1'b0, pos_ff} < add_ff) begin
                        mem_req.rd_en = 1'b1;
                        mem_req.addr  = pos_ff[STORE_AW-1:0];
                        state_in      = ST_READ;
                     end else begin
                        status_in = STATUS_REFUSED;
                     end
                  end
                  default: begin
                     status_in = STATUS_REFUSED;
                  end
               endcase
            end
         end

         ST_GROW: begin
            // new capacity always exceeds the fill level, so the append goes through
            if (grow_done) begin
               cap_in        = grow_cap;
               mem_req.wr_en = 1'b1;
               mem_req.addr  = add_ff[STORE_AW-1:0];
               mem_req.wdata = sym_ff;
               add_in        = add_ff + 1'b1;
               state_in      = ST_DONE;
            end
         end

         ST_READ: begin
            data_in  = mem_rdata;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, (add_ff == '0), (add_ff == cap_ff), cap_ff[14:0],
                               mark_ff[14:0], rd_ff[14:0], add_ff[14:0], eob_ff,
                               data_ff, status_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a write to the mode, step or start register starts a fresh buffer
      if (csr_wen) begin
         unique case (csr_addr)
            CSR_MODE:  mode_in  = csr_wdata[1:0];
            CSR_STEP:  step_in  = csr_wdata[7:0];
            CSR_START: start_in = csr_wdata;
            default:   ;
         endcase
         if (csr_addr == CSR_MODE || csr_addr == CSR_STEP || csr_addr == CSR_START) begin
            add_in  = '0;
            rd_in   = '0;
            mark_in = '0;
            eob_in  = 1'b0;
            cap_in  = {1'b0, (csr_addr == CSR_START) ? csr_wdata : start_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RESET;
         step_ff      <= STEP_RESET;
         start_ff     <= START_RESET;
         add_ff       <= '0;
         rd_ff        <= '0;
         mark_ff      <= '0;
         cap_ff       <= {1'b0, START_RESET};
         eob_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         step_ff      <= step_in;
         start_ff     <= start_in;
         add_ff       <= add_in;
         rd_ff        <= rd_in;
         mark_ff      <= mark_in;
         cap_ff       <= cap_in;
         eob_ff       <= eob_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      sym_ff      <= sym_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      data_ff     <= data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule : growable_char_buffer_with_mark_top
`default_nettype wire
